FILE: src/signed_decimal_seven_segment_shifter_macros.svh
// Assertion macros shared by the checker of the seven-segment shifter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_SHIFTER_MACROS_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_SHIFTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDSS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdss assertion failed");

// Next-cycle implication, checked outside reset.
`define SDSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdss assertion failed");

`endif

FILE: src/sdss_pkg.sv
// Package of the seven-segment shifter: frame type, constants, segment tables.
// No dependencies; used by the front, queue, back and top-level files.
`timescale 1ns / 1ps
`default_nettype none

package sdss_pkg;

    localparam int FRAME_BITS = 32;
    localparam int PLACE_BITS = 8;
    localparam int CNT_W      = $clog2(FRAME_BITS);

    // Reciprocal of ten scaled by 2^19; exact for dividends below 81920.
    localparam logic [15:0] RECIP10       = 16'd52429;
    localparam int          RECIP10_SHIFT = 19;

    localparam logic [6:0] BLANK_CODE = 7'h00;
    localparam logic [6:0] MINUS_CODE = 7'h40;

    localparam logic CMD_PRINT = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic                  animate;
    } frame_t;

    // Segment pattern for a decimal digit, bit 6 = g ... bit 0 = a, 1 = lit.
    function automatic logic [6:0] digit_code(input logic [3:0] digit);
        logic [6:0] code;
        unique case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

    // Serial bits of one place, bit 0 goes out first: decimal point, then g down to a.
    // Active low, so a lit segment becomes 0.
    function automatic logic [PLACE_BITS-1:0] place_bits(input logic [6:0] code);
        logic [PLACE_BITS-1:0] bits;
        bits[0] = 1'b1;
        for (int k = 1; k < PLACE_BITS; k++)
        begin
            bits[k] = ~code[7-k];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

FILE: src/sdss_front.sv
// Front part of the seven-segment shifter: accepts beats, splits the magnitude into
// digits over two registered stages and builds the 32-bit frame. Depends on sdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdss_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cmd,
    input  wire logic signed [14:0]   value,
    input  wire logic                 animate,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output sdss_pkg::frame_t          push_frame
);
    import sdss_pkg::*;

    // Stage one: sign, magnitude and magnitude / 10.
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_cmd_reg, s1_neg_reg, s1_anim_reg;
    logic [14:0] s1_mag_reg;
    logic [10:0] s1_q1_reg;

    // Stage two: units digit and magnitude / 100.
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_cmd_reg, s2_neg_reg, s2_anim_reg;
    logic [10:0] s2_q1_reg;
    logic [7:0]  s2_q2_reg;
    logic [3:0]  s2_units_reg;

    logic        en1, en2;
    logic [14:0] mag_c;
    logic [30:0] prod1;
    logic [26:0] prod2;
    logic [14:0] q1x10;
    logic [14:0] units_diff;
    logic [10:0] q2x10;
    logic [10:0] tens_diff;
    logic [3:0]  tens;
    logic [6:0]  code_units, code_tens, code_hund, code_sign;

    assign en2      = !s2_valid_reg || push_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    assign s1_valid_next = en1 ? in_valid : s1_valid_reg;
    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;

    assign mag_c = value[14] ? (~$unsigned(value) + 15'd1) : $unsigned(value);
    assign prod1 = 31'(mag_c) * 31'(RECIP10);

    assign prod2      = 27'(s1_q1_reg) * 27'(RECIP10);
    assign q1x10      = 15'({s1_q1_reg, 3'b000}) + 15'({s1_q1_reg, 1'b0});
    assign units_diff = s1_mag_reg - q1x10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cmd_reg  <= cmd;
            s1_neg_reg  <= value[14];
            s1_anim_reg <= animate;
            s1_mag_reg  <= mag_c;
            s1_q1_reg   <= prod1[RECIP10_SHIFT+10:RECIP10_SHIFT];
        end
        if (en2)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_anim_reg  <= s1_anim_reg;
            s2_q1_reg    <= s1_q1_reg;
            s2_q2_reg    <= prod2[RECIP10_SHIFT+7:RECIP10_SHIFT];
            s2_units_reg <= units_diff[3:0];
        end
    end

    // Frame assembly from the stage-two digits.
    assign q2x10     = 11'({s2_q2_reg, 3'b000}) + 11'({s2_q2_reg, 1'b0});
    assign tens_diff = s2_q1_reg - q2x10;
    assign tens      = tens_diff[3:0];

    always_comb
    begin
        code_units = digit_code(s2_units_reg);
        code_tens  = digit_code(tens);
        priority if (s2_q2_reg == 8'd0)
        begin
            code_hund = BLANK_CODE;
            if (tens == 4'd0)
            begin
                code_tens = BLANK_CODE;
            end
        end
        else if (s2_q2_reg >= 8'd10)
        begin
            code_hund = BLANK_CODE;
        end
        else
        begin
            code_hund = digit_code(s2_q2_reg[3:0]);
        end
        code_sign = s2_neg_reg ? MINUS_CODE : BLANK_CODE;
    end

    always_comb
    begin
        push_frame.animate = s2_anim_reg;
        if (s2_cmd_reg == CMD_CLEAR)
        begin
            push_frame.bits = '1;
        end
        else
        begin
            push_frame.bits = {place_bits(code_sign), place_bits(code_hund),
                               place_bits(code_tens), place_bits(code_units)};
        end
    end

    assign push_valid = s2_valid_reg;

endmodule

`default_nettype wire

FILE: src/sdss_queue.sv
// Two-entry frame queue between the front and back parts of the shifter.
// Depends on sdss_pkg for the frame type.
`timescale 1ns / 1ps
`default_nettype none

module sdss_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  sdss_pkg::frame_t   push_frame,
    output logic               push_ready,
    input  wire logic          pop,
    output logic               empty,
    output sdss_pkg::frame_t   head_frame
);
    import sdss_pkg::*;

    frame_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign empty      = (count_reg == 2'd0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && !empty;
    assign head_frame = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

FILE: src/sdss_back.sv
// Back part of the shifter: takes frames from the queue and shifts them out one bit
// per output beat, units place first. Depends on sdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdss_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  sdss_pkg::frame_t   q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               serial_data,
    output logic               latch_pulse,
    output logic               last
);
    import sdss_pkg::*;

    logic                  valid_reg, valid_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic                  anim_reg, anim_next;
    logic                  take, at_end, load;

    assign at_end = (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign take   = valid_reg && !out_stall;
    assign load   = !valid_reg || (take && at_end);
    assign q_pop  = load && !q_empty;

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        anim_next  = anim_reg;
        if (load)
        begin
            valid_next = !q_empty;
            cnt_next   = '0;
            shift_next = q_head.bits;
            anim_next  = q_head.animate;
        end
        else if (take)
        begin
            cnt_next   = cnt_reg + CNT_W'(1);
            shift_next = {1'b1, shift_reg[FRAME_BITS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        anim_reg  <= anim_next;
    end

    assign out_valid   = valid_reg;
    assign serial_data = shift_reg[0];
    assign last        = at_end;
    assign latch_pulse = anim_reg || at_end;

endmodule

`default_nettype wire

FILE: src/signed_decimal_seven_segment_shifter.sv
// Top level of the signed decimal seven-segment shifter.
// Instantiates sdss_front, sdss_queue and sdss_back; depends on sdss_pkg.
//
// Usage. The input channel (in_valid, in_stall) carries one command per beat:
// cmd selects print or clear, value is the signed number and animate asks for a
// latch strobe after every bit. The output channel (out_valid, out_stall) carries
// one shift-register bit per beat: serial_data (active low segment level),
// latch_pulse and last, which marks the 32nd bit of a frame.
// Each accepted input beat becomes exactly 32 output beats, the units place first.
// An accepted input beat passes through the two digit stages, a queue entry and the
// output shift register, whose bit 0 is the first bit shown on serial_data.
// The output shift register moves one bit per output beat while out_stall is low; when
// the queue holds the next frame, frames follow each other with no gap cycle.
// The front keeps accepting while the back is shifting, until its two stages and the
// two-entry queue are full; then in_stall rises.
// When the receiver stalls, the current bit holds on the output pins and shifting
// pauses; back pressure reaches the input only once the queue is full.
// Reset (rst_n low, asynchronous) empties the pipeline and the queue; no frame is
// in flight afterwards and out_valid is low.
`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_seven_segment_shifter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic signed [14:0] value,
    input  wire logic               animate,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    serial_data,
    output logic                    latch_pulse,
    output logic                    last
);
    import sdss_pkg::*;

    // Frame hand-over from the front to the queue.
    logic   push_valid;
    logic   push_ready;
    frame_t push_frame;

    // Queue head towards the back.
    logic   q_empty;
    logic   q_pop;
    frame_t q_head;

    // The front classifies each beat and turns it into a full 32-bit frame.
    sdss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .value      (value),
        .animate    (animate),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    // A short queue decouples frame building from the slow serial output.
    sdss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_frame (push_frame),
        .push_ready (push_ready),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_frame (q_head)
    );

    // The back shifts each frame out bit by bit.
    sdss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .serial_data (serial_data),
        .latch_pulse (latch_pulse),
        .last        (last)
    );

endmodule

`default_nettype wire

FILE: src/sdss_checker.sv
// Port-level checker of the seven-segment shifter, bound to the top level.
// Depends on signed_decimal_seven_segment_shifter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_decimal_seven_segment_shifter_macros.svh"

module sdss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        serial_data,
    input wire logic        latch_pulse,
    input wire logic        last
);

    // The payload of one output beat, gathered so that it can be checked as a whole.
    logic [2:0] out_beat;

    assign out_beat = {serial_data, latch_pulse, last};

    // A stalled output beat holds.
    `SDSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

    // The latch is always strobed on the final bit of a frame.
    `SDSS_ASSERT_IMPL(a_last_latches, out_valid && last, latch_pulse)

    // A frame, once started, continues without gaps until its last bit.
    `SDSS_ASSERT_NEXT(a_frame_continues, out_valid && !out_stall && !last, out_valid)

    // The bit after a frame's last bit never closes a frame itself.
    `SDSS_ASSERT_NEXT(a_last_single, out_valid && !out_stall && last, !last)

endmodule

bind signed_decimal_seven_segment_shifter sdss_checker u_sdss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .serial_data (serial_data),
    .latch_pulse (latch_pulse),
    .last        (last)
);

`default_nettype wire
